@@ design/assert_macros.svh @@
// Assertion macros shared by the chord note generator modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Property that must hold even while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

@@ design/bcng_pkg.sv @@
// Shared types, codes and constants of the button chord note generator.
// No dependencies; used by every module of the block.
package bcng_pkg;

	localparam int ROWS = 4;
	localparam int COLUMNS = 12;
	localparam int CELLS = ROWS * COLUMNS;
	localparam int CELL_BITS = $clog2(CELLS);
	localparam int COUNT_BITS = 4;
	localparam int NOTE_SLOTS = 5;
	localparam int ALL_OFF_MESSAGES = 32;
	localparam int MSG_INDEX_BITS = $clog2(ALL_OFF_MESSAGES);
	localparam int CMD_QUEUE_DEPTH = 2;
	localparam int SEMITONES = 12;
	localparam int NOTE_MAX = 127;

	// Root note of each column, circle of fifths starting at E flat.
	localparam logic [5:0] ROOT_TABLE [COLUMNS] = '{
		6'd39, 6'd46, 6'd41, 6'd36, 6'd43, 6'd38,
		6'd45, 6'd40, 6'd47, 6'd42, 6'd37, 6'd44
	};

	localparam logic [1:0] KIND_PRESS = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_ALL_OFF = 2'd2;

	localparam logic [1:0] ROW_COUNTERBASS = 2'd0;
	localparam logic [1:0] ROW_BASS = 2'd1;
	localparam logic [1:0] ROW_MAJOR = 2'd2;
	localparam logic [1:0] ROW_MINOR = 2'd3;

	localparam logic [1:0] MSG_NOTE_ON = 2'd0;
	localparam logic [1:0] MSG_NOTE_OFF = 2'd1;
	localparam logic [1:0] MSG_ALL_NOTES_OFF = 2'd2;
	localparam logic [1:0] MSG_ALL_SOUND_OFF = 2'd3;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OCT_COUNTERBASS = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OCT_BASS = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OCT_MAJOR = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OCT_MINOR = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENSIONS = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAJOR_INV = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MINOR_INV = 3'd6;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] row_index;
		logic [3:0] column_index;
		logic [6:0] velocity;
		logic       left_held;
		logic       right_held;
	} in_item_t;

	typedef struct packed {
		logic [1:0] message_type;
		logic [3:0] channel;
		logic [6:0] note_number;
		logic [6:0] note_velocity;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]                  count;
		logic [NOTE_SLOTS-1:0][6:0]  notes;
	} chord_t;

	typedef enum logic [1:0] {
		CMD_NOTE_ON,
		CMD_NOTE_OFF,
		CMD_ALL_OFF
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [6:0] velocity;
		chord_t     chord;
	} cmd_t;

	typedef enum logic {
		FS_IDLE,
		FS_DECIDE
	} front_state_t;

endpackage

@@ design/button_chord_note_generator_unit.sv @@
// Chord button note generator: button events for a 4 by 12 grid go in through
// a queue-style port and MIDI-style messages come out the same way. A front
// end takes each event at the accept edge, which also reads the press
// counter and chord memories, then in a decide state updates them and, for an
// event that sounds, queues a command, waiting there while the command queue
// is full. A sequencer then takes the command and emits one message per note,
// or 32 for all-off; the output register's one transfer per cycle, held while
// the consumer does not pop, bounds the sustained rate. Configuration is
// written through cfg_we, cfg_index and cfg_data and takes effect at once.
module button_chord_note_generator_unit #(
	parameter int COUNT_BITS = bcng_pkg::COUNT_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  bcng_pkg::in_item_t                   item,
	output logic                                 empty,
	input  logic                                 pop,
	output bcng_pkg::out_item_t                  result,
	input  logic                                 cfg_we,
	input  logic [bcng_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [bcng_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	bcng_pkg::cmd_t cmd_wr, cmd_rd;

	bcng_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd_full  (cmd_full),
		.cmd       (cmd_wr)
	);

	bcng_cmd_queue #(
		.DEPTH(bcng_pkg::CMD_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.full    (cmd_full),
		.wr_data (cmd_wr),
		.pop     (cmd_pop),
		.empty   (cmd_empty),
		.rd_data (cmd_rd)
	);

	bcng_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_rd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

@@ design/bcng_front.sv @@
// Front end: takes button events, keeps the press counters, the stored chords
// and the configuration, and queues one command per event that sounds.
// Depends on bcng_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcng_front #(
	parameter int COUNT_BITS = bcng_pkg::COUNT_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  bcng_pkg::in_item_t                     item,
	input  logic                                   cfg_we,
	input  logic [bcng_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [bcng_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output logic                                   cmd_push,
	input  logic                                   cmd_full,
	output bcng_pkg::cmd_t                         cmd
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	bcng_pkg::front_state_t state_q, next_state;
	bcng_pkg::in_item_t item_q;

	logic signed [2:0] oct_cb_q, oct_bass_q, oct_major_q, oct_minor_q;
	logic [3:0] ext_q;
	logic [1:0] major_inv_q, minor_inv_q;

	logic [COUNT_BITS-1:0] count_mem [bcng_pkg::CELLS];
	bcng_pkg::chord_t chord_mem [bcng_pkg::CELLS];
	logic [COUNT_BITS-1:0] count_rd_s1;
	bcng_pkg::chord_t chord_rd_s1;
	logic [bcng_pkg::CELLS-1:0] count_valid_q;

	logic accept, deciding, col_ok, is_press, is_release, is_all_off;
	logic need_cmd, stall, count_we, chord_we;
	logic [bcng_pkg::CELL_BITS-1:0] rd_addr, addr_q;
	logic [COUNT_BITS-1:0] cur_count, count_wdata;
	logic signed [2:0] row_shift;
	logic [1:0] row_ext, row_steps;
	bcng_pkg::chord_t built_chord;

	function automatic logic [bcng_pkg::CELL_BITS-1:0] cell_addr(
		input logic [1:0] row,
		input logic [3:0] col
	);
		logic [bcng_pkg::CELL_BITS-1:0] r;
		r = bcng_pkg::CELL_BITS'(row);
		// row * 12 as two shifts
		return (r << 3) + (r << 2) + bcng_pkg::CELL_BITS'(col);
	endfunction

	function automatic bcng_pkg::chord_t build_chord(
		input logic [1:0]        row,
		input logic [3:0]        col,
		input logic              left,
		input logic              right,
		input logic signed [2:0] shift,
		input logic [1:0]        ext,
		input logic [1:0]        steps
	);
		int root, oct, b, n, s, i, v;
		int t [bcng_pkg::NOTE_SLOTS];
		logic sev, nin;
		bcng_pkg::chord_t c;
		for (i = 0; i < bcng_pkg::NOTE_SLOTS; i++) begin
			t[i] = 0;
		end
		root = int'(bcng_pkg::ROOT_TABLE[col]);
		oct = bcng_pkg::SEMITONES * int'(shift);
		sev = left && ext[0];
		nin = right && ext[1];
		s = 0;
		n = 1;
		if (row == bcng_pkg::ROW_COUNTERBASS) begin
			t[0] = root + 4 + oct;
		end else if (row == bcng_pkg::ROW_BASS) begin
			t[0] = root + oct;
		end else begin
			b = root + bcng_pkg::SEMITONES + oct;
			t[0] = b;
			t[1] = (row == bcng_pkg::ROW_MINOR) ? b + 3 : b + 4;
			t[2] = b + 7;
			if (sev) begin
				t[3] = b + 10;
			end
			if (nin) begin
				if (sev) begin
					t[4] = b + 14;
				end else begin
					t[3] = b + 14;
				end
			end
			n = 3 + int'(sev) + int'(nin);
			s = (steps > 2'd2) ? 2 : int'(steps);
		end
		c.count = 3'(n);
		// Each inversion moves the lowest note an octave up to the top.
		for (i = 0; i < bcng_pkg::NOTE_SLOTS; i++) begin
			if (i < n - s) begin
				v = t[i + s];
			end else if (i < n) begin
				v = t[i - (n - s)] + bcng_pkg::SEMITONES;
			end else begin
				v = 0;
			end
			if (v < 0) begin
				c.notes[i] = 7'd0;
			end else if (v > bcng_pkg::NOTE_MAX) begin
				c.notes[i] = 7'(bcng_pkg::NOTE_MAX);
			end else begin
				c.notes[i] = 7'(v);
			end
		end
		return c;
	endfunction

	assign accept = push && !full;
	assign rd_addr = cell_addr(item.row_index, item.column_index);
	assign addr_q = cell_addr(item_q.row_index, item_q.column_index);

	// Classification of the held event, valid in the decide state.
	always_comb begin
		col_ok = item_q.column_index < 4'(bcng_pkg::COLUMNS);
		is_press = (item_q.kind == bcng_pkg::KIND_PRESS) && col_ok;
		is_release = (item_q.kind == bcng_pkg::KIND_RELEASE) && col_ok;
		is_all_off = item_q.kind == bcng_pkg::KIND_ALL_OFF;
		cur_count = count_valid_q[addr_q] ? count_rd_s1 : '0;
		need_cmd = is_all_off || (is_press && cur_count == '0)
			|| (is_release && cur_count == COUNT_ONE);
		count_wdata = is_press ? cur_count + COUNT_ONE : cur_count - COUNT_ONE;
	end

	always_comb begin
		unique case (item_q.row_index)
			bcng_pkg::ROW_COUNTERBASS: row_shift = oct_cb_q;
			bcng_pkg::ROW_BASS: row_shift = oct_bass_q;
			bcng_pkg::ROW_MAJOR: row_shift = oct_major_q;
			bcng_pkg::ROW_MINOR: row_shift = oct_minor_q;
		endcase
		row_ext = (item_q.row_index == bcng_pkg::ROW_MINOR) ? ext_q[3:2] : ext_q[1:0];
		row_steps = (item_q.row_index == bcng_pkg::ROW_MINOR) ? minor_inv_q : major_inv_q;
		built_chord = build_chord(item_q.row_index, item_q.column_index,
			item_q.left_held, item_q.right_held, row_shift, row_ext, row_steps);
	end

	// Next state
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			bcng_pkg::FS_IDLE: begin
				if (push) begin
					next_state = bcng_pkg::FS_DECIDE;
				end
			end
			bcng_pkg::FS_DECIDE: begin
				if (!(need_cmd && cmd_full)) begin
					next_state = bcng_pkg::FS_IDLE;
				end
			end
		endcase
	end

	// State outputs
	always_comb begin
		full = 1'b1;
		deciding = 1'b0;
		unique case (state_q)
			bcng_pkg::FS_IDLE: full = 1'b0;
			bcng_pkg::FS_DECIDE: deciding = 1'b1;
		endcase
		stall = need_cmd && cmd_full;
		cmd_push = deciding && need_cmd && !cmd_full;
		count_we = deciding && !stall
			&& ((is_press && cur_count != COUNT_MAX) || (is_release && cur_count != '0));
		chord_we = deciding && !stall && is_press && cur_count == '0;
		cmd.velocity = item_q.velocity;
		if (is_all_off) begin
			cmd.kind = bcng_pkg::CMD_ALL_OFF;
			cmd.chord = chord_rd_s1;
		end else if (is_press) begin
			cmd.kind = bcng_pkg::CMD_NOTE_ON;
			cmd.chord = built_chord;
		end else begin
			cmd.kind = bcng_pkg::CMD_NOTE_OFF;
			cmd.chord = chord_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcng_pkg::FS_IDLE;
			count_valid_q <= '0;
		end else begin
			state_q <= next_state;
			if (deciding && is_all_off && !stall) begin
				count_valid_q <= '0;
			end else if (count_we) begin
				count_valid_q[addr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cb_q <= '0;
			oct_bass_q <= '0;
			oct_major_q <= '0;
			oct_minor_q <= '0;
			ext_q <= '0;
			major_inv_q <= '0;
			minor_inv_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcng_pkg::REG_OCT_COUNTERBASS: oct_cb_q <= cfg_data[2:0];
				bcng_pkg::REG_OCT_BASS: oct_bass_q <= cfg_data[2:0];
				bcng_pkg::REG_OCT_MAJOR: oct_major_q <= cfg_data[2:0];
				bcng_pkg::REG_OCT_MINOR: oct_minor_q <= cfg_data[2:0];
				bcng_pkg::REG_EXTENSIONS: ext_q <= cfg_data;
				bcng_pkg::REG_MAJOR_INV: major_inv_q <= cfg_data[1:0];
				bcng_pkg::REG_MINOR_INV: minor_inv_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// Press counter memory: written in the decide cycle, read at the accept edge.
	always_ff @(posedge clk) begin
		if (count_we) begin
			count_mem[addr_q] <= count_wdata;
		end
		if (accept) begin
			count_rd_s1 <= count_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (chord_we) begin
			chord_mem[addr_q] <= built_chord;
		end
		if (accept) begin
			chord_rd_s1 <= chord_mem[rd_addr];
		end
	end

	`ASSERT_PROP(a_accept_then_busy, clk, arst_n, push && !full |=> full,
		"front accepted a second event without deciding the first")
	`ASSERT_PROP(a_no_push_when_full, clk, arst_n, cmd_push |-> !cmd_full,
		"command pushed into a full queue")
	`ASSERT_PROP(a_single_write, clk, arst_n, count_we |-> !(is_all_off || cmd_full && need_cmd),
		"counter written while clearing or stalled")

endmodule

@@ design/bcng_cmd_queue.sv @@
// Short command queue between the front end and the message sequencer.
// Depends on bcng_pkg.
module bcng_cmd_queue #(
	parameter int DEPTH = bcng_pkg::CMD_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  bcng_pkg::cmd_t  wr_data,
	input  logic            pop,
	output logic            empty,
	output bcng_pkg::cmd_t  rd_data
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

	bcng_pkg::cmd_t entries [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] fill_q;
	logic do_push, do_pop;

	assign full = fill_q == CNT_BITS'(DEPTH);
	assign empty = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_data = entries[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/bcng_back.sv @@
// Back end: expands each queued command into its burst of messages and holds
// the oldest waiting message in the output register.
// Depends on bcng_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcng_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcng_pkg::cmd_t       cmd,
	input  logic                 cmd_empty,
	output logic                 cmd_pop,
	output bcng_pkg::out_item_t  result,
	output logic                 empty,
	input  logic                 pop
);

	logic busy_q, out_valid_q, load;
	bcng_pkg::cmd_t cmd_q;
	logic [bcng_pkg::MSG_INDEX_BITS-1:0] idx_q;
	bcng_pkg::out_item_t msg, out_q;

	assign cmd_pop = !busy_q && !cmd_empty;
	assign load = busy_q && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign result = out_q;

	always_comb begin
		msg.message_type = bcng_pkg::MSG_NOTE_ON;
		msg.channel = 4'd0;
		msg.note_number = cmd_q.chord.notes[idx_q[2:0]];
		msg.note_velocity = 7'd0;
		msg.last = idx_q == bcng_pkg::MSG_INDEX_BITS'(cmd_q.chord.count - 3'd1);
		case (cmd_q.kind)
			bcng_pkg::CMD_NOTE_ON: begin
				msg.note_velocity = cmd_q.velocity;
			end
			bcng_pkg::CMD_NOTE_OFF: begin
				msg.message_type = bcng_pkg::MSG_NOTE_OFF;
			end
			bcng_pkg::CMD_ALL_OFF: begin
				// Two controller messages per channel, notes off first.
				msg.message_type = idx_q[0] ? bcng_pkg::MSG_ALL_SOUND_OFF
					: bcng_pkg::MSG_ALL_NOTES_OFF;
				msg.channel = idx_q[4:1];
				msg.note_number = 7'd0;
				msg.last = idx_q == bcng_pkg::MSG_INDEX_BITS'(bcng_pkg::ALL_OFF_MESSAGES - 1);
			end
			default: begin
				msg.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd_pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (load) begin
				if (msg.last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (load) begin
			out_q <= msg;
		end
	end

	`ASSERT_PROP(a_last_ends_burst, clk, arst_n, load && msg.last |=> !busy_q,
		"sequencer kept running after the final message")
	`ASSERT_PROP(a_note_index_range, clk, arst_n,
		busy_q && cmd_q.kind != bcng_pkg::CMD_ALL_OFF |-> idx_q < 5'(cmd_q.chord.count),
		"note index beyond the stored chord")
	`ASSERT_PROP(a_no_overwrite, clk, arst_n, out_valid_q && !pop |=> $stable(out_q),
		"waiting message overwritten before transfer")

endmodule
